// ===== design/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PNGSFS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// Overlapping implication checked on every clock edge outside reset.
`define PNGSFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

// ===== design/pngsfs_pkg.sv =====
// -----------------------------------------------------------------------------
// PNG scanline filter select package
// Types, constants and helper functions shared by the filter select block.
// -----------------------------------------------------------------------------
package pngsfs_pkg;

  localparam int unsigned DEF_MAX_WIDTH       = 1024;
  localparam int unsigned DEF_BYTES_PER_PIXEL = 4;
  localparam int unsigned CFG_W               = 11;
  localparam int unsigned COST_W              = 20;
  localparam int unsigned NUM_SLOTS           = 3;
  localparam int unsigned SLOT_W              = 2;

  localparam logic FUNC_RAW   = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    FILT_NONE = 2'd0,
    FILT_SUB  = 2'd1,
    FILT_UP   = 2'd2
  } filter_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] filter_type;
    logic       row_first;
    logic       row_last;
  } out_word_t;

  // One entry of the row memory holds the byte of every row slot at one column.
  typedef logic [NUM_SLOTS-1:0][7:0] row_word_t;

  typedef struct packed {
    logic              raw;
    logic [7:0]        x;
    logic [7:0]        a;
    logic              b_ok;
    logic              emit;
    logic              sub_ok;
    logic              has_above;
    logic              row_first;
    logic              row_last;
    logic              row_end;
    logic [SLOT_W-1:0] pend_slot;
    logic [SLOT_W-1:0] above_slot;
  } stage_t;

  function automatic logic [7:0] mag(input logic [7:0] r);
    return r[7] ? 8'(8'd0 - r) : r;
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] acc,
                                                input logic [7:0] v);
    logic [COST_W:0] sum;
    sum = {1'b0, acc} + (COST_W+1)'(v);
    return sum[COST_W] ? '1 : sum[COST_W-1:0];
  endfunction

endpackage

// ===== design/pngsfs_row_mem.sv =====
// -----------------------------------------------------------------------------
// Row memory
// Three row slots side by side in one word, one slot lane written per cycle,
// two registered read ports.
// -----------------------------------------------------------------------------
module pngsfs_row_mem #(
  parameter int unsigned MAX_WIDTH       = pngsfs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned BYTES_PER_PIXEL = pngsfs_pkg::DEF_BYTES_PER_PIXEL,
  localparam int unsigned Depth = MAX_WIDTH * BYTES_PER_PIXEL,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AddrW-1:0]                  waddr_i,
  input  logic [pngsfs_pkg::SLOT_W-1:0]     wslot_i,
  input  logic [7:0]                        wdata_i,
  input  logic                              re_i,
  input  logic [AddrW-1:0]                  raddr0_i,
  input  logic [AddrW-1:0]                  raddr1_i,
  output pngsfs_pkg::row_word_t             rdata0_o,
  output pngsfs_pkg::row_word_t             rdata1_o
);
  import pngsfs_pkg::*;

  row_word_t mem_q [Depth];
  row_word_t rdata0_q;
  row_word_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wslot_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== design/pngsfs_ctrl.sv =====
// -----------------------------------------------------------------------------
// Filter select control
// Accepts input words, keeps row counters and slot rotation, drives the row
// memory and hands each word to the data path stage.
// -----------------------------------------------------------------------------
module pngsfs_ctrl #(
  parameter int unsigned MAX_WIDTH       = pngsfs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned BYTES_PER_PIXEL = pngsfs_pkg::DEF_BYTES_PER_PIXEL,
  localparam int unsigned RowBytes = MAX_WIDTH * BYTES_PER_PIXEL,
  localparam int unsigned AddrW    = (RowBytes > 1) ? $clog2(RowBytes) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  pngsfs_pkg::in_word_t          in_word_i,
  output logic                          in_stall_o,
  input  logic                          cfg_we_i,
  input  logic [pngsfs_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                          b_adv_i,
  output logic                          b_valid_o,
  output pngsfs_pkg::stage_t            b_o,
  output logic                          mem_we_o,
  output logic [AddrW-1:0]              mem_waddr_o,
  output logic [pngsfs_pkg::SLOT_W-1:0] mem_wslot_o,
  output logic [7:0]                    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AddrW-1:0]              mem_raddr0_o,
  output logic [AddrW-1:0]              mem_raddr1_o
);
  import pngsfs_pkg::*;

  localparam int unsigned CntW = $clog2(RowBytes + 1);

  localparam logic [1:0] ROWS_NONE  = 2'd0;
  localparam logic [1:0] ROWS_FIRST = 2'd1;
  localparam logic [1:0] ROWS_TWO   = 2'd2;

  logic [CntW-1:0]   len_q, cfg_len;
  logic [CntW-1:0]   idx_q, idx_d, idx_inc;
  logic [CntW-1:0]   pos_q, pos_d, pos_inc;
  logic [SLOT_W-1:0] row_slot_q, row_slot_d, pend_slot, above_slot;
  logic [1:0]        rows_seen_q, rows_seen_d, rows_seen_inc;
  logic              b_valid_q;
  stage_t            b_q, st;
  logic [7:0]        tap_q [BYTES_PER_PIXEL];
  logic              accept, is_raw, have_pend, emit, row_last, row_end;

  assign in_stall_o = b_valid_q && !b_adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_raw     = (in_word_i.func == FUNC_RAW);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_len = CntW'(BYTES_PER_PIXEL);
    end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
      cfg_len = CntW'(RowBytes);
    end else begin
      cfg_len = CntW'(32'(cfg_wdata_i) * BYTES_PER_PIXEL);
    end
  end

  always_comb begin
    unique case (row_slot_q)
      2'd0:    begin pend_slot = 2'd2; above_slot = 2'd1; end
      2'd1:    begin pend_slot = 2'd0; above_slot = 2'd2; end
      default: begin pend_slot = 2'd1; above_slot = 2'd0; end
    endcase
  end

  always_comb begin
    unique case (rows_seen_q)
      ROWS_NONE: rows_seen_inc = ROWS_FIRST;
      default:   rows_seen_inc = ROWS_TWO;
    endcase
  end

  assign have_pend = (rows_seen_q != ROWS_NONE);
  assign emit      = have_pend && (pos_q < len_q);
  assign pos_inc   = pos_q + CntW'(1);
  assign idx_inc   = idx_q + CntW'(1);
  assign row_last  = (pos_inc >= len_q);
  assign row_end   = (idx_inc >= len_q);

  always_comb begin
    st.raw        = is_raw;
    st.x          = in_word_i.data_byte;
    st.a          = (idx_q >= CntW'(BYTES_PER_PIXEL)) ? tap_q[BYTES_PER_PIXEL-1] : 8'h00;
    st.b_ok       = have_pend;
    st.emit       = emit;
    st.sub_ok     = (pos_q >= CntW'(BYTES_PER_PIXEL));
    st.has_above  = (rows_seen_q == ROWS_TWO);
    st.row_first  = (pos_q == '0);
    st.row_last   = row_last;
    st.row_end    = is_raw && row_end;
    st.pend_slot  = pend_slot;
    st.above_slot = above_slot;
  end

  always_comb begin
    idx_d       = idx_q;
    pos_d       = pos_q;
    row_slot_d  = row_slot_q;
    rows_seen_d = rows_seen_q;
    if (accept) begin
      if (is_raw) begin
        idx_d = idx_inc;
        pos_d = emit ? pos_inc : pos_q;
        if (row_end) begin
          row_slot_d  = above_slot;
          rows_seen_d = rows_seen_inc;
          idx_d       = '0;
          pos_d       = '0;
        end
      end else begin
        idx_d = '0;
        if (!emit || row_last) begin
          rows_seen_d = ROWS_NONE;
          pos_d       = '0;
        end else begin
          pos_d = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= CntW'(BYTES_PER_PIXEL);
      idx_q       <= '0;
      pos_q       <= '0;
      row_slot_q  <= '0;
      rows_seen_q <= ROWS_NONE;
      b_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_len;
      end
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      row_slot_q  <= row_slot_d;
      rows_seen_q <= rows_seen_d;
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_adv_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q <= st;
    end
    if (accept && is_raw) begin
      tap_q[0] <= in_word_i.data_byte;
      for (int i = 1; i < BYTES_PER_PIXEL; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign b_valid_o    = b_valid_q;
  assign b_o          = b_q;
  assign mem_we_o     = accept && is_raw;
  assign mem_waddr_o  = idx_q[AddrW-1:0];
  assign mem_wslot_o  = row_slot_q;
  assign mem_wdata_o  = in_word_i.data_byte;
  assign mem_re_o     = accept;
  assign mem_raddr0_o = pos_q[AddrW-1:0];
  assign mem_raddr1_o = idx_q[AddrW-1:0];

endmodule

// ===== design/pngsfs_datapath.sv =====
// -----------------------------------------------------------------------------
// Filter select data path
// Accumulates the three row costs, picks the row filter and forms the
// filtered output word from the row memory read data.
// -----------------------------------------------------------------------------
module pngsfs_datapath #(
  parameter int unsigned BYTES_PER_PIXEL = pngsfs_pkg::DEF_BYTES_PER_PIXEL
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  b_valid_i,
  input  pngsfs_pkg::stage_t    b_i,
  input  pngsfs_pkg::row_word_t rdata0_i,
  input  pngsfs_pkg::row_word_t rdata1_i,
  output logic                  b_adv_o,
  output logic                  out_valid_o,
  output pngsfs_pkg::out_word_t out_word_o,
  input  logic                  out_stall_i
);
  import pngsfs_pkg::*;

  logic [COST_W-1:0] cost_none_q, cost_sub_q, cost_up_q;
  logic [COST_W-1:0] none_sum, sub_sum, up_sum, best_cost;
  filter_e           pend_filter_q, best;
  logic [7:0]        etap_q [BYTES_PER_PIXEL];
  logic [7:0]        v, up_byte, b_byte, ref_byte;
  logic              out_valid_q, fire;
  out_word_t         out_q, res;

  assign b_adv_o = !b_i.emit || !out_valid_q || !out_stall_i;
  assign fire    = b_valid_i && b_adv_o;

  assign v       = rdata0_i[b_i.pend_slot];
  assign up_byte = rdata0_i[b_i.above_slot];
  assign b_byte  = b_i.b_ok ? rdata1_i[b_i.pend_slot] : 8'h00;

  always_comb begin
    unique case (pend_filter_q)
      FILT_SUB: ref_byte = b_i.sub_ok ? etap_q[BYTES_PER_PIXEL-1] : 8'h00;
      FILT_UP:  ref_byte = b_i.has_above ? up_byte : 8'h00;
      default:  ref_byte = 8'h00;
    endcase
  end

  always_comb begin
    res.out_byte    = 8'(v - ref_byte);
    res.filter_type = pend_filter_q;
    res.row_first   = b_i.row_first;
    res.row_last    = b_i.row_last;
  end

  assign none_sum = sat_add(cost_none_q, mag(b_i.x));
  assign sub_sum  = sat_add(cost_sub_q, mag(8'(b_i.x - b_i.a)));
  assign up_sum   = sat_add(cost_up_q, mag(8'(b_i.x - b_byte)));

  always_comb begin
    best      = FILT_NONE;
    best_cost = none_sum;
    if (sub_sum < best_cost) begin
      best      = FILT_SUB;
      best_cost = sub_sum;
    end
    if (up_sum < best_cost) begin
      best = FILT_UP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_none_q   <= '0;
      cost_sub_q    <= '0;
      cost_up_q     <= '0;
      pend_filter_q <= FILT_NONE;
      out_valid_q   <= 1'b0;
    end else begin
      if (fire) begin
        if (!b_i.raw || b_i.row_end) begin
          cost_none_q <= '0;
          cost_sub_q  <= '0;
          cost_up_q   <= '0;
        end else begin
          cost_none_q <= none_sum;
          cost_sub_q  <= sub_sum;
          cost_up_q   <= up_sum;
        end
        if (b_i.raw && b_i.row_end) begin
          pend_filter_q <= best;
        end
      end
      if (fire && b_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && b_i.emit) begin
      out_q    <= res;
      etap_q[0] <= v;
      for (int i = 1; i < BYTES_PER_PIXEL; i++) begin
        etap_q[i] <= etap_q[i-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== design/png_scanline_filter_select_top.sv =====
// -----------------------------------------------------------------------------
// PNG scanline filter select, top level
// Accepts one word per cycle while in_stall_o is low; a result passes the
// stage register and registered row memory read, then the output register.
// Reset clears all control state; the row memory is not cleared.
// -----------------------------------------------------------------------------
module png_scanline_filter_select_top #(
  parameter int unsigned MAX_WIDTH       = pngsfs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned BYTES_PER_PIXEL = pngsfs_pkg::DEF_BYTES_PER_PIXEL
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  pngsfs_pkg::in_word_t         in_word_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  output pngsfs_pkg::out_word_t        out_word_o,
  input  logic                         out_stall_i,
  input  logic                         cfg_we_i,
  input  logic [pngsfs_pkg::CFG_W-1:0] cfg_wdata_i
);
  import pngsfs_pkg::*;

  localparam int unsigned RowBytes = MAX_WIDTH * BYTES_PER_PIXEL;
  localparam int unsigned AddrW    = (RowBytes > 1) ? $clog2(RowBytes) : 1;

  logic              b_adv, b_valid;
  stage_t            b_stage;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr0, mem_raddr1;
  logic [SLOT_W-1:0] mem_wslot;
  logic [7:0]        mem_wdata;
  row_word_t         rdata0, rdata1;

  pngsfs_ctrl #(
    .MAX_WIDTH       (MAX_WIDTH),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word_i),
    .in_stall_o   (in_stall_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .b_adv_i      (b_adv),
    .b_valid_o    (b_valid),
    .b_o          (b_stage),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wslot_o  (mem_wslot),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr0_o (mem_raddr0),
    .mem_raddr1_o (mem_raddr1)
  );

  pngsfs_row_mem #(
    .MAX_WIDTH       (MAX_WIDTH),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wslot_i  (mem_wslot),
    .wdata_i  (mem_wdata),
    .re_i     (mem_re),
    .raddr0_i (mem_raddr0),
    .raddr1_i (mem_raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  pngsfs_datapath #(
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .b_valid_i   (b_valid),
    .b_i         (b_stage),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1),
    .b_adv_o     (b_adv),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== design/pngsfs_checker.sv =====
// -----------------------------------------------------------------------------
// Filter select port checker
// Watches the top level ports for handshake and timing properties.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pngsfs_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_i,
  input logic                  out_valid_i,
  input pngsfs_pkg::out_word_t out_word_i,
  input logic                  out_stall_i
);
  import pngsfs_pkg::*;

  `PNGSFS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
  `PNGSFS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i)
  `PNGSFS_ASSERT(a_out_after_in, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && !in_stall_i, 2))

endmodule

bind png_scanline_filter_select_top pngsfs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_word_i  (out_word_o),
  .out_stall_i (out_stall_i)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// PNG scanline filter select testbench
// Streams RGBA rows, drain words and random noise into the filter selector.
// Idle gaps and stalls are random on both sides, and one long output hold-off
// is included. The image width is changed between phases, including the
// extreme settings. A behavioral predictor tracks the row store, costs and
// pending row, and every output word is checked field by field in order.
// -----------------------------------------------------------------------------
module tb_top;
  import pngsfs_pkg::*;

  localparam int unsigned BPP            = DEF_BYTES_PER_PIXEL;
  localparam int unsigned ROW_MAX        = DEF_MAX_WIDTH * DEF_BYTES_PER_PIXEL;
  localparam int unsigned COST_MAX       = (1 << COST_W) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned LONG_PART      = 256;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_word_t         in_word   = '0;
  logic             in_stall;
  logic             out_valid;
  out_word_t        out_word;
  logic             out_stall = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  png_scanline_filter_select_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .out_stall_i (out_stall),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state.
  logic [7:0]       row_mem [NUM_SLOTS][ROW_MAX];
  logic [CFG_W-1:0] width_reg;
  int unsigned      cur_slot, col_cnt, rows_held, emit_pos;
  int unsigned      sum_none, sum_sub, sum_up;
  filter_e          pend_filt;

  // Stimulus and checking state.
  in_word_t    stim_q [$];
  out_word_t   filtered_q [$];
  out_word_t   pred_word;
  out_word_t   exp_word;
  logic [7:0]  gen_row [ROW_MAX];
  logic [7:0]  gen_prev [ROW_MAX];
  int unsigned queued_cnt   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned src_gap, snk_gap, hold_left, idle_cycles;
  bit          hold_done;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  bit          hold_arm    = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned row_bytes_for(input logic [CFG_W-1:0] w);
    int unsigned eff;
    eff = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
    return eff * BPP;
  endfunction

  function automatic int unsigned cost_of(input logic [7:0] r);
    return (r > 8'd127) ? 32'd256 - r : r;
  endfunction

  function automatic int unsigned add_sat(input int unsigned acc, input int unsigned v);
    return (acc + v > COST_MAX) ? COST_MAX : acc + v;
  endfunction

  function automatic void clear_image();
    col_cnt   = 0;
    rows_held = 0;
    emit_pos  = 0;
    sum_none  = 0;
    sum_sub   = 0;
    sum_up    = 0;
  endfunction

  function automatic bit emit_pending_byte(input int unsigned len, output out_word_t w);
    int unsigned pend, above;
    logic [7:0]  v, ref_b;
    pend  = (cur_slot + 2) % 3;
    above = (cur_slot + 1) % 3;
    w     = '0;
    if (rows_held == 0 || emit_pos >= len) return 1'b0;
    v     = row_mem[pend][emit_pos];
    ref_b = 8'd0;
    if (pend_filt == FILT_SUB && emit_pos >= BPP) ref_b = row_mem[pend][emit_pos - BPP];
    else if (pend_filt == FILT_UP && rows_held >= 2) ref_b = row_mem[above][emit_pos];
    w.out_byte    = v - ref_b;
    w.filter_type = pend_filt;
    w.row_first   = (emit_pos == 0);
    w.row_last    = (emit_pos + 1 >= len);
    emit_pos++;
    return 1'b1;
  endfunction

  function automatic bit filter_byte(input in_word_t w, output out_word_t res);
    int unsigned len, cur, pend, idx, best;
    logic [7:0]  x, a, b;
    bit          hit;
    len = row_bytes_for(width_reg);
    res = '0;
    if (w.func == FUNC_DRAIN) begin
      if (rows_held == 0 || emit_pos >= len) begin
        clear_image();
        return 1'b0;
      end
      col_cnt  = 0;
      sum_none = 0;
      sum_sub  = 0;
      sum_up   = 0;
      hit = emit_pending_byte(len, res);
      if (emit_pos >= len) clear_image();
      return hit;
    end
    cur  = cur_slot;
    pend = (cur_slot + 2) % 3;
    idx  = col_cnt;
    x    = w.data_byte;
    a    = 8'd0;
    b    = 8'd0;
    hit  = emit_pending_byte(len, res);
    if (idx >= BPP) a = row_mem[cur][idx - BPP];
    if (rows_held > 0) b = row_mem[pend][idx];
    row_mem[cur][idx] = x;
    sum_none = add_sat(sum_none, cost_of(x));
    sum_sub  = add_sat(sum_sub, cost_of(8'(x - a)));
    sum_up   = add_sat(sum_up, cost_of(8'(x - b)));
    col_cnt  = idx + 1;
    if (col_cnt >= len) begin
      pend_filt = FILT_NONE;
      best      = sum_none;
      if (sum_sub < best) begin
        pend_filt = FILT_SUB;
        best      = sum_sub;
      end
      if (sum_up < best) pend_filt = FILT_UP;
      cur_slot = (cur + 1) % 3;
      if (rows_held < 2) rows_held++;
      col_cnt  = 0;
      emit_pos = 0;
      sum_none = 0;
      sum_sub  = 0;
      sum_up   = 0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Input driver.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      src_gap  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (filter_byte(in_word, pred_word)) filtered_q.push_back(pred_word);
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (src_idle_en && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_word  <= stim_q.pop_front();
        end
      end
    end
  end

  // Output stall generator.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Output checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("word with none expected", 32'(out_word), 0);
        end else begin
          exp_word = filtered_q.pop_front();
          if (out_word.out_byte !== exp_word.out_byte)
            report_mismatch("out_byte", 32'(out_word.out_byte), 32'(exp_word.out_byte));
          if (out_word.filter_type !== exp_word.filter_type)
            report_mismatch("filter_type", 32'(out_word.filter_type),
                            32'(exp_word.filter_type));
          if (out_word.row_first !== exp_word.row_first)
            report_mismatch("row_first", 32'(out_word.row_first), 32'(exp_word.row_first));
          if (out_word.row_last !== exp_word.row_last)
            report_mismatch("row_last", 32'(out_word.row_last), 32'(exp_word.row_last));
        end
      end
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
          (stim_q.size() == 0 && !in_valid && filtered_q.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic push_raw(input logic [7:0] b);
    stim_q.push_back(in_word_t'{func: FUNC_RAW, data_byte: b});
    queued_cnt++;
  endtask

  task automatic push_drains(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      stim_q.push_back(in_word_t'{func: FUNC_DRAIN, data_byte: 8'($urandom_range(0, 255))});
      queued_cnt++;
    end
  endtask

  task automatic push_row(input int unsigned mode, input int unsigned n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: b = 8'($urandom_range(0, 255));
        1: b = (i < BPP) ? 8'($urandom_range(0, 255)) :
                           gen_row[i - BPP] + 8'($urandom_range(0, 3));
        2: b = gen_prev[i] + 8'($urandom_range(0, 2)) - 8'd1;
        3: b = 8'($urandom_range(0, 4)) - 8'd2;
        default: begin
          case ($urandom_range(0, 3))
            0: b = 8'h00;
            1: b = 8'h7f;
            2: b = 8'h80;
            default: b = 8'hff;
          endcase
        end
      endcase
      gen_row[i] = b;
      push_raw(b);
    end
    for (int i = 0; i < n; i++) gen_prev[i] = gen_row[i];
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (stim_q.size() != 0 || in_valid || filtered_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // A wider row is only allowed once no row is pending, so that every byte
  // read back from the row store has been written.
  task automatic set_width(input logic [CFG_W-1:0] w);
    wait_idle();
    if (rows_held != 0 && row_bytes_for(w) > row_bytes_for(width_reg)) begin
      push_drains(row_bytes_for(width_reg));
      wait_idle();
    end
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    width_reg = w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase();
    logic [CFG_W-1:0] w;
    int unsigned      len, nrows;
    src_idle_en = ($urandom_range(0, 3) != 0);
    snk_idle_en = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = CFG_W'($urandom_range(9, 16));
      default: w = CFG_W'($urandom_range(1, 8));
    endcase
    set_width(w);
    len = row_bytes_for(width_reg);
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < 24; i++) begin
        stim_q.push_back(in_word_t'{func: ($urandom_range(0, 3) == 0) ? FUNC_DRAIN : FUNC_RAW,
                                    data_byte: 8'($urandom_range(0, 255))});
      end
      return;
    end
    nrows = $urandom_range(1, 4);
    for (int r = 0; r < nrows; r++) begin
      push_row($urandom_range(0, 4), len);
      if ($urandom_range(0, 5) == 0) push_drains($urandom_range(1, len - 1));
    end
    case ($urandom_range(0, 3))
      0:       push_row($urandom_range(0, 4), $urandom_range(1, len - 1));
      1:       ;
      default: push_drains(len + $urandom_range(0, 1));
    endcase
  endtask

  initial begin
    int unsigned start_cnt;
    width_reg = 11'd1;
    cur_slot  = 0;
    pend_filt = FILT_NONE;
    clear_image();
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset width of one pixel.
    push_drains(1);
    push_raw(8'h00); push_raw(8'hff); push_raw(8'h80); push_raw(8'h7f);
    push_raw(8'h01); push_raw(8'hff); push_raw(8'h81); push_raw(8'h7e);
    push_raw(8'h10); push_raw(8'h20); push_raw(8'h30);
    push_drains(1);
    push_raw(8'h40); push_raw(8'h50); push_raw(8'h60); push_raw(8'h70);
    push_drains(4);

    // The output is held off while rows keep coming in.
    set_width(11'd8);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_arm    = 1'b1;
    for (int r = 0; r < 6; r++) push_row(r % 5, 32);
    push_drains(32);

    // Width above the maximum: a long partial row that the next, narrower
    // width then closes on its first byte.
    set_width('1);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    push_row(1, LONG_PART);

    start_cnt = queued_cnt;
    while (queued_cnt - start_cnt < RANDOM_ITEMS) random_phase();

    // Closing part without idle cycles.
    set_width(11'd5);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int r = 0; r < 3; r++) push_row(r, 20);
    push_drains(20);
    wait_idle();
    repeat (12) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== png_scanline_filter_select_top.f =====
+incdir+design
design/pngsfs_pkg.sv
design/pngsfs_row_mem.sv
design/pngsfs_ctrl.sv
design/pngsfs_datapath.sv
design/png_scanline_filter_select_top.sv
design/pngsfs_checker.sv
tb/tb_top.sv
